FILE: rtl/d3pp_pkg.sv
// Package for the dot-product phase-to-phasor block: widths, CORDIC constants,
// the arctangent table and the stage record handed from cell to cell.
// No dependencies.
`default_nettype none

package d3pp_pkg;

    // CORDIC iteration count and phase precision.
    localparam int CORDIC_STEPS = 16;
    localparam int PHASE_BITS   = 32;

    // Arctangent table size and the width of a step index.
    localparam int ATAN_ENTRIES = 24;
    localparam int STEP_W       = $clog2(ATAN_ENTRIES);

    // Number of cells actually built (the table bounds it).
    localparam int NUM_CELLS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    // Field widths.
    localparam int POINT_W = 24;
    localparam int DIR_W   = 18;
    localparam int PROD_W  = POINT_W + DIR_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int SCALE_W = 32;
    localparam int OUT_W   = 16;

    // Input and output bus widths.
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 32;

    // The product is only needed modulo 2**52; the dot product splits at this bit.
    localparam int WRAP_W  = 52;
    localparam int SPLIT_W = 26;
    localparam int DHI_W   = DOT_W - SPLIT_W;

    // Vector and angle widths inside the CORDIC (Q2.30 with headroom).
    localparam int XW = 34;
    localparam int ZW = 34;

    // Initial x, the inverse CORDIC gain in Q2.30.
    localparam logic signed [XW-1:0] INV_GAIN_Q30 = XW'(652032874);

    // Mask that keeps the phase bits the chosen precision resolves.
    localparam logic [31:0] PHASE_MASK = (PHASE_BITS >= 32) ? 32'hFFFF_FFFF :
                                         ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);

    // Quadrant codes: nearest quarter turn of the phase.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Vector state carried along the chain of cells.
    typedef struct packed {
        logic [1:0]             quad;
        logic signed [XW-1:0]   x;
        logic signed [XW-1:0]   y;
        logic signed [ZW-1:0]   z;
    } cordic_t;

    // Arctangent of 2**-i in 32-bit turns.
    function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/d3pp_phase.sv
// Phase front end: three products, dot product, wide scale multiply in two
// halves, wrap to one turn and quadrant split. Four register stages.
// Depends on d3pp_pkg.
`default_nettype none

module d3pp_phase (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                ce,
    input  wire logic                                in_valid,
    input  wire logic signed [d3pp_pkg::POINT_W-1:0] point_x,
    input  wire logic signed [d3pp_pkg::POINT_W-1:0] point_y,
    input  wire logic signed [d3pp_pkg::POINT_W-1:0] point_z,
    input  wire logic signed [d3pp_pkg::DIR_W-1:0]   dir_x,
    input  wire logic signed [d3pp_pkg::DIR_W-1:0]   dir_y,
    input  wire logic signed [d3pp_pkg::DIR_W-1:0]   dir_z,
    input  wire logic signed [d3pp_pkg::SCALE_W-1:0] phase_scale,
    output logic                                     out_valid,
    output d3pp_pkg::cordic_t                        out_data
);

    localparam int LO_W = d3pp_pkg::SPLIT_W + 1 + d3pp_pkg::SCALE_W;
    localparam int HI_W = d3pp_pkg::DHI_W + d3pp_pkg::SCALE_W;

    logic [3:0] valid_reg;

    logic signed [d3pp_pkg::PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [d3pp_pkg::DOT_W-1:0]  dot_reg, dot_next;
    logic signed [LO_W-1:0]             lo_full;
    logic signed [HI_W-1:0]             hi_full;
    logic [d3pp_pkg::WRAP_W-1:0]        lo_reg;
    logic [d3pp_pkg::SPLIT_W-1:0]       hi_reg;
    logic [d3pp_pkg::WRAP_W-1:0]        prod;
    logic [31:0]                        phase;
    logic [31:0]                        phase_rnd;
    logic [1:0]                         quad;
    logic [31:0]                        resid;
    d3pp_pkg::cordic_t                  cell_next;
    d3pp_pkg::cordic_t                  cell_reg;

    // Valid bits move with the stage enable.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // Stage one: the three products.
    always_ff @(posedge aclk) begin
        if (ce) begin
            px_reg <= d3pp_pkg::PROD_W'(point_x) * d3pp_pkg::PROD_W'(dir_x);
            py_reg <= d3pp_pkg::PROD_W'(point_y) * d3pp_pkg::PROD_W'(dir_y);
            pz_reg <= d3pp_pkg::PROD_W'(point_z) * d3pp_pkg::PROD_W'(dir_z);
        end
    end

    // Stage two: exact dot product.
    assign dot_next = d3pp_pkg::DOT_W'(px_reg) + d3pp_pkg::DOT_W'(py_reg)
                    + d3pp_pkg::DOT_W'(pz_reg);

    always_ff @(posedge aclk) begin
        if (ce) begin
            dot_reg <= dot_next;
        end
    end

    // Stage three: scale multiply split into an unsigned low half and a signed
    // high half of the dot product; only the product modulo 2**52 is kept.
    assign lo_full = LO_W'($signed({1'b0, dot_reg[d3pp_pkg::SPLIT_W-1:0]}))
                   * LO_W'(phase_scale);
    assign hi_full = HI_W'($signed(dot_reg[d3pp_pkg::DOT_W-1:d3pp_pkg::SPLIT_W]))
                   * HI_W'(phase_scale);

    always_ff @(posedge aclk) begin
        if (ce) begin
            lo_reg <= lo_full[d3pp_pkg::WRAP_W-1:0];
            hi_reg <= hi_full[d3pp_pkg::SPLIT_W-1:0];
        end
    end

    // Stage four: wrapped phase, nearest quarter turn and residual angle.
    always_comb begin
        prod      = lo_reg + {hi_reg, {d3pp_pkg::SPLIT_W{1'b0}}};
        phase     = prod[d3pp_pkg::WRAP_W-1:d3pp_pkg::WRAP_W-32] & d3pp_pkg::PHASE_MASK;
        phase_rnd = phase + 32'h2000_0000;
        quad      = phase_rnd[31:30];
        resid     = phase - {quad, 30'd0};

        cell_next.quad = quad;
        cell_next.x    = d3pp_pkg::INV_GAIN_Q30;
        cell_next.y    = '0;
        cell_next.z    = d3pp_pkg::ZW'($signed(resid));
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = cell_reg;

endmodule

`default_nettype wire

FILE: rtl/d3pp_cell.sv
// One CORDIC rotation cell: conditional add/subtract of the shifted vector and
// the arctangent of its step, registered. Depends on d3pp_pkg.
`default_nettype none

module d3pp_cell (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               ce,
    input  wire logic [d3pp_pkg::STEP_W-1:0]        step_idx,
    input  wire logic                               in_valid,
    input  wire d3pp_pkg::cordic_t                  in_data,
    output logic                                    out_valid,
    output d3pp_pkg::cordic_t                       out_data
);

    logic                           valid_reg;
    d3pp_pkg::cordic_t              data_reg, data_next;
    logic signed [d3pp_pkg::XW-1:0] xs, ys;
    logic signed [d3pp_pkg::ZW-1:0] ang;

    // Rotate toward zero residual angle.
    always_comb begin
        xs  = in_data.x >>> step_idx;
        ys  = in_data.y >>> step_idx;
        ang = $signed(d3pp_pkg::ZW'(d3pp_pkg::atan_turns(step_idx)));

        data_next.quad = in_data.quad;
        if (!in_data.z[d3pp_pkg::ZW-1]) begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - ang;
        end else begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: rtl/d3pp_out.sv
// Output stage: quarter-turn rotation, rounding to Q1.15 with saturation, the
// output register and a skid register that holds one transaction while the
// consumer stalls. Depends on d3pp_pkg.
`default_nettype none

module d3pp_out (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    input  wire d3pp_pkg::cordic_t                    in_data,
    output logic                                      ce,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [d3pp_pkg::OUT_DATA_W-1:0]           m_tdata
);

    localparam int RND_W = d3pp_pkg::XW + 1;

    logic                                  out_valid_reg, out_valid_next;
    logic                                  skid_valid_reg, skid_valid_next;
    logic [d3pp_pkg::OUT_DATA_W-1:0]       out_data_reg;
    logic [d3pp_pkg::OUT_DATA_W-1:0]       skid_data_reg;
    logic [d3pp_pkg::OUT_DATA_W-1:0]       result;
    logic signed [d3pp_pkg::XW-1:0]        xr, yr;
    logic                                  out_ready;
    logic                                  load_new, load_skid, fill_skid;

    // Round half up at bit 15 and clamp to the Q1.15 range.
    function automatic logic [d3pp_pkg::OUT_W-1:0] to_q15(input logic signed [d3pp_pkg::XW-1:0] v);
        logic signed [RND_W-1:0] s;
        logic signed [RND_W-1:0] r;
        logic [d3pp_pkg::OUT_W-1:0] q;
        s = RND_W'(v) + RND_W'(16384);
        r = s >>> 15;
        if (r > RND_W'(32767)) begin
            q = 16'h7FFF;
        end else if (r < -RND_W'(32768)) begin
            q = 16'h8000;
        end else begin
            q = r[d3pp_pkg::OUT_W-1:0];
        end
        return q;
    endfunction

    // Exact rotation by the quarter turns taken off the phase.
    always_comb begin
        unique case (in_data.quad)
            d3pp_pkg::QUAD_1: begin
                xr = -in_data.y;
                yr = in_data.x;
            end
            d3pp_pkg::QUAD_2: begin
                xr = -in_data.x;
                yr = -in_data.y;
            end
            d3pp_pkg::QUAD_3: begin
                xr = in_data.y;
                yr = -in_data.x;
            end
            default: begin
                xr = in_data.x;
                yr = in_data.y;
            end
        endcase
        result = {to_q15(yr), to_q15(xr)};
    end

    // The pipeline advances whenever the skid register is empty.
    assign ce        = !skid_valid_reg;
    assign out_ready = !out_valid_reg || m_tready;

    // Output and skid register control.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_new        = 1'b0;
        load_skid       = 1'b0;
        fill_skid       = 1'b0;
        if (out_ready) begin
            if (skid_valid_reg) begin
                load_skid       = 1'b1;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                load_new       = in_valid;
                out_valid_next = in_valid;
            end
        end else if (!skid_valid_reg && in_valid) begin
            fill_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_skid) begin
            out_data_reg <= skid_data_reg;
        end else if (load_new) begin
            out_data_reg <= result;
        end
        if (fill_skid) begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/dot3_phase_to_phasor_top.sv
// Pipeline: 4 phase stages, NUM_CELLS (16) CORDIC cells and 1 output register.
// Throughput: one transaction per cycle while the skid register is empty; every stage is a
// register and the chain of CORDIC cells holds one item per cell.
// Reset (aresetn low, synchronous) empties the pipeline and sets phase_scale to 1.0.
// Top level of the dot-product phase-to-phasor block; depends on d3pp_pkg,
// d3pp_phase, d3pp_cell and d3pp_out.
`default_nettype none

module dot3_phase_to_phasor_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration: phase_scale, Q8.24 turns per unit.
    input  wire logic                                cfg_we,
    input  wire logic [d3pp_pkg::SCALE_W-1:0]        cfg_wdata,
    // Input: point_x, point_y, point_z, dir_x, dir_y, dir_z from bit 0 up, zero pad.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [d3pp_pkg::IN_DATA_W-1:0]      s_tdata,
    // Output: cos_part, sin_part from bit 0 up.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [d3pp_pkg::OUT_DATA_W-1:0]          m_tdata
);

    logic signed [d3pp_pkg::SCALE_W-1:0] phase_scale_reg;
    logic                                ce;
    logic                                chain_valid [0:d3pp_pkg::NUM_CELLS];
    d3pp_pkg::cordic_t                   chain_data  [0:d3pp_pkg::NUM_CELLS];

    // Scale factor register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_scale_reg <= 32'sd16777216;
        end else if (cfg_we) begin
            phase_scale_reg <= cfg_wdata;
        end
    end

    assign s_tready = ce;

    // Dot product, scaling and quadrant split.
    d3pp_phase u_phase (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ce          (ce),
        .in_valid    (s_tvalid),
        .point_x     ($signed(s_tdata[23:0])),
        .point_y     ($signed(s_tdata[47:24])),
        .point_z     ($signed(s_tdata[71:48])),
        .dir_x       ($signed(s_tdata[89:72])),
        .dir_y       ($signed(s_tdata[107:90])),
        .dir_z       ($signed(s_tdata[125:108])),
        .phase_scale (phase_scale_reg),
        .out_valid   (chain_valid[0]),
        .out_data    (chain_data[0])
    );

    // Chain of CORDIC cells, one step each.
    for (genvar k = 0; k < d3pp_pkg::NUM_CELLS; k++) begin : g_cell
        d3pp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .step_idx  (d3pp_pkg::STEP_W'(k)),
            .in_valid  (chain_valid[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    // Quadrant rotation, rounding and the output registers.
    d3pp_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chain_valid[d3pp_pkg::NUM_CELLS]),
        .in_data  (chain_data[d3pp_pkg::NUM_CELLS]),
        .ce       (ce),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
